>>> sv/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants for the prime range counter.
// ----------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

    // Width of the request and result fields
    localparam int FIELD_WIDTH = 16;

    // Default width of the tested values
    localparam int VALUE_WIDTH_DEFAULT = 16;

    // Smallest prime
    localparam int FIRST_PRIME = 2;

    // Saturation limit of the prime count
    localparam logic [FIELD_WIDTH-1:0] COUNT_MAX = '1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Status returned by the remainder unit
    typedef struct packed {
        logic done;
        logic rem_zero;
    } mod_status_t;

endpackage

`default_nettype wire

>>> sv/prime_range_counter_core.sv
// ----------------------------------------------------------------------------
// prime_range_counter_core
// Counts the primes in [range_start, range_end) by trial division.
// ----------------------------------------------------------------------------
// Usage: a request beat on the in channel (in_valid, in_stall) carries
// range_start (inclusive) and range_end (exclusive). One result beat on the
// out channel (out_valid, out_stall) carries prime_count. An empty or
// reversed range gives a count of zero; 0 and 1 are never prime.
// Each value v in the range is tested against divisors d = 2, 3, ... while
// d*d <= v. Every divisor tried costs one pass of the shared remainder unit
// plus a visit to the check state. Each value also passes once through the
// scan state; the remainder passes dominate the run time of a request.
// One request is worked at a time: in_stall is high while a count runs.
// The result sits in an output register; a new request is taken while it
// waits, but the next result is held back until the earlier one is taken.
// Under out_stall the result beat holds. Reset clears the sequencer and the
// output valid; nothing else needs clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_range_counter_core #(
    parameter int VALUE_WIDTH = prc_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic [prc_pkg::FIELD_WIDTH-1:0]   range_start,
    input  wire logic [prc_pkg::FIELD_WIDTH-1:0]   range_end,
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [prc_pkg::FIELD_WIDTH-1:0]   prime_count
);

    // Tested values are the request fields cut to VALUE_WIDTH bits, at most FIELD_WIDTH
    localparam int VW = (VALUE_WIDTH < prc_pkg::FIELD_WIDTH) ? VALUE_WIDTH
                                                             : prc_pkg::FIELD_WIDTH;
    localparam int CW = prc_pkg::FIELD_WIDTH;

    prc_pkg::state_t      state_reg, state_next;
    logic [VW-1:0]        value_reg, value_next;
    logic [VW-1:0]        end_reg, end_next;
    logic [VW-1:0]        div_reg, div_next;
    logic [VW:0]          dsq_reg, dsq_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CW-1:0]        result_reg, result_next;
    logic                 mod_start;
    prc_pkg::mod_status_t mod_status;
    logic                 in_accept;
    logic                 out_free;

    assign in_accept = in_valid && (state_reg == prc_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Shared remainder unit
    prc_mod_unit #(
        .VALUE_WIDTH (VW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (value_reg),
        .divisor  (div_reg),
        .status   (mod_status)
    );

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        end_next       = end_reg;
        div_next       = div_reg;
        dsq_next       = dsq_reg;
        count_next     = count_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        mod_start      = 1'b0;
        case (state_reg)
            prc_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    value_next = range_start[VW-1:0];
                    end_next   = range_end[VW-1:0];
                    count_next = '0;
                    state_next = prc_pkg::ST_SCAN;
                end
            end
            prc_pkg::ST_SCAN:
            begin
                // Stop at the range end, skip values below the first prime
                if (value_reg >= end_reg)
                begin
                    state_next = prc_pkg::ST_FINISH;
                end
                else if (value_reg < VW'(prc_pkg::FIRST_PRIME))
                begin
                    value_next = value_reg + 1'b1;
                end
                else
                begin
                    div_next   = VW'(prc_pkg::FIRST_PRIME);
                    dsq_next   = (VW+1)'(prc_pkg::FIRST_PRIME * prc_pkg::FIRST_PRIME);
                    state_next = prc_pkg::ST_CHECK;
                end
            end
            prc_pkg::ST_CHECK:
            begin
                // Divisor squared past the value: no divisor found, count it
                if (dsq_reg > {1'b0, value_reg})
                begin
                    if (count_reg != prc_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    value_next = value_reg + 1'b1;
                    state_next = prc_pkg::ST_SCAN;
                end
                else
                begin
                    mod_start  = 1'b1;
                    state_next = prc_pkg::ST_DIVIDE;
                end
            end
            prc_pkg::ST_DIVIDE:
            begin
                if (mod_status.done)
                begin
                    if (mod_status.rem_zero)
                    begin
                        // Composite: drop it and advance
                        value_next = value_reg + 1'b1;
                        state_next = prc_pkg::ST_SCAN;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        div_next   = div_reg + 1'b1;
                        dsq_next   = dsq_reg + {div_reg, 1'b1};
                        state_next = prc_pkg::ST_CHECK;
                    end
                end
            end
            prc_pkg::ST_FINISH:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    result_next    = count_reg;
                    out_valid_next = 1'b1;
                    state_next     = prc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prc_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        end_reg    <= end_next;
        div_reg    <= div_next;
        dsq_reg    <= dsq_next;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

    assign in_stall    = (state_reg != prc_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign prime_count = result_reg;

endmodule

`default_nettype wire

>>> sv/prc_mod_unit.sv
// ----------------------------------------------------------------------------
// prc_mod_unit
// Restoring remainder unit: one quotient bit per cycle, and after the last
// bit a one-cycle done pulse with a zero-remainder flag.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_mod_unit #(
    parameter int VALUE_WIDTH = prc_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [VALUE_WIDTH-1:0]  dividend,
    input  wire logic [VALUE_WIDTH-1:0]  divisor,
    output prc_pkg::mod_status_t         status
);

    localparam int CntW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CntW-1:0]        cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial = {rem_reg, shift_reg[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, divisor};
    end

    // Step control
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CntW'(VALUE_WIDTH - 1);
            rem_next   = '0;
            shift_next = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[VALUE_WIDTH-1:0];
            end
            else
            begin
                rem_next = trial[VALUE_WIDTH-1:0];
            end
            shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

`default_nettype wire
